@@ hw/rtl/radix_k_palindrome_check_top_macros.svh @@
// ----------------------------------------------------------------------------
// radix_k_palindrome_check_top_macros.svh
// Assertion helpers for the base-k palindrome tester; they expect clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RADIX_K_PALINDROME_CHECK_TOP_MACROS_SVH
`define RADIX_K_PALINDROME_CHECK_TOP_MACROS_SVH

// Same-cycle implication, held off during reset
`define RKP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset
`define RKP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rkp_pkg.sv @@
// ----------------------------------------------------------------------------
// rkp_pkg
// Shared types and constants of the base-k palindrome tester.
// ----------------------------------------------------------------------------
`default_nettype none

package rkp_pkg;

	// Radix register
	localparam int          RADIX_W     = 6;
	localparam logic [5:0]  RADIX_RESET = 6'd10;
	localparam logic [5:0]  RADIX_MIN   = 6'd2;

	// Quotient bits produced per divider cycle
	localparam int          STEP_BITS   = 8;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture input value, clear reversal
		logic div_step;  // STEP_BITS restoring-division steps
		logic acc;       // fold digit into reversed value
		logic emit;      // write result register
	} rkp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic num_zero;  // running quotient is zero
		logic out_free;  // result register can take a new result
	} rkp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rkp_channels.sv @@
// ----------------------------------------------------------------------------
// rkp_channels
// Valid/ready channel interfaces: input value, result and radix write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkp_value_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rkp_result_if;
	logic valid;
	logic ready;
	logic is_palindrome;

	modport source (output valid, output is_palindrome, input ready);
	modport sink   (input valid, input is_palindrome, output ready);
endinterface

interface rkp_radix_if;
	logic       valid;
	logic       ready;
	logic [5:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rkp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkp_ctrl
// Sequencer: one digit per pass of test, divide cycles and accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module rkp_ctrl #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  rkp_pkg::rkp_status_t status,
	output rkp_pkg::rkp_cmd_t    cmd
);
	import rkp_pkg::*;

	localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TEST = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             last_div;

	assign last_div = (cnt_q == CNT_W'(DIV_CYCLES - 1));
	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				cnt_d = '0;
				if (status.num_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (last_div) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_TEST;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and divide-cycle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rkp_datapath.sv @@
// ----------------------------------------------------------------------------
// rkp_datapath
// Radix register, shared restoring divider, digit reversal and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rkp_datapath #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire  [rkp_pkg::RADIX_W-1:0]  cfg_radix,
	input  wire  [VALUE_WIDTH-1:0]       value,
	input  rkp_pkg::rkp_cmd_t            cmd,
	output rkp_pkg::rkp_status_t         status,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         out_pal
);
	import rkp_pkg::*;

	localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int W_PAD      = DIV_CYCLES * STEP_BITS;
	localparam int REV_W      = VALUE_WIDTH + RADIX_W;

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base_q;
	logic [W_PAD-1:0]       num_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [REV_W-1:0]       rev_q;
	logic [VALUE_WIDTH-1:0] orig_q;
	logic                   out_valid_q;
	logic                   out_pal_q;

	logic [RADIX_W:0]       part;
	logic [STEP_BITS-1:0]   qbits;
	logic [RADIX_W-1:0]     rem_next;

	// Restoring division, STEP_BITS quotient bits MSB first
	always_comb begin
		part  = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			part = {part[RADIX_W-1:0], num_q[W_PAD-1-i]};
			if (part >= {1'b0, base_q}) begin
				qbits[STEP_BITS-1-i] = 1'b1;
				part                 = part - {1'b0, base_q};
			end
		end
		rem_next = part[RADIX_W-1:0];
	end

	assign status.num_zero = (num_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	// Radix register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= cfg_radix;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= W_PAD'(value);
			orig_q <= value;
			rev_q  <= '0;
			rem_q  <= '0;
			base_q <= (radix_q < RADIX_MIN) ? RADIX_MIN : radix_q;
		end else if (cmd.div_step) begin
			num_q <= (num_q << STEP_BITS) | W_PAD'(qbits);
			rem_q <= rem_next;
		end else if (cmd.acc) begin
			// reversed value grows by one digit; bounded by radix * value
			rev_q <= REV_W'(rev_q * base_q) + REV_W'(rem_q);
			rem_q <= '0;
		end
		if (cmd.emit) begin
			out_pal_q <= (rev_q == REV_W'(orig_q));
		end
	end

	assign out_valid = out_valid_q;
	assign out_pal   = out_pal_q;

endmodule

`default_nettype wire

@@ hw/rtl/radix_k_palindrome_check_top.sv @@
// ----------------------------------------------------------------------------
// radix_k_palindrome_check_top
// Tests whether a value reads the same both ways in a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input, one unsigned value per transfer.
//   result : valid/ready output, one is_palindrome bit per item.
//   cfg    : valid/ready radix write, always ready; write only while idle.
//            Radix 0 and 1 act as radix 2.
// Sequence:
//   One item at a time. Each base-k digit takes a test step, the divide
//   steps of the shared restoring divider (8 quotient bits a cycle) and an
//   accumulate step. After the last digit a test finds the quotient zero
//   and the result is written to the output register; a zero value goes
//   straight from the test to the result. The next item can be taken in the
//   cycle after the result is written. The digit loop through the divider
//   sets the time an item takes.
// Reset: arst_n clears the sequencer and result valid and sets radix 10.
// Stall: the result waits in an output register; the next item is taken and
//   worked on meanwhile, then holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_k_palindrome_check_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	rkp_value_if.sink    item,
	rkp_result_if.source result,
	rkp_radix_if.sink    cfg
);
	import rkp_pkg::*;

	rkp_cmd_t    cmd;
	rkp_status_t status;
	logic        in_ready;

	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;

	// Sequencer
	rkp_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Divider, reversal and result register
	rkp_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_radix (cfg.radix),
		.value     (VALUE_WIDTH'(item.value)),
		.cmd       (cmd),
		.status    (status),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_pal   (result.is_palindrome)
	);

	// Checks
`include "radix_k_palindrome_check_top_macros.svh"

	`RKP_ASSERT_NOW(a_emit_free, cmd.emit, (!result.valid || result.ready), "result overwritten")
	`RKP_ASSERT_NEXT(a_busy_after_take, (item.valid && item.ready), !item.ready, "took item while busy")
	`RKP_ASSERT_NEXT(a_emit_shows, cmd.emit, result.valid, "result not shown after emit")

endmodule

`default_nettype wire
